@@ rtl/tqu_pkg.sv @@
// Shared types, constants and tables of the triangular quantile pipeline.
package tqu_pkg;

  localparam int EXPW     = 25;  // width of exp() result, Q24, up to 1 + 2^-24
  localparam int EXP_LAT  = 39;  // register stages in tqu_exp
  localparam int SQRT_LAT = 32;  // register stages in tqu_isqrt, one root bit each

  localparam logic [EXPW-1:0] ONE_Q24 = EXPW'(25'h100_0000);

  // configuration register indexes
  localparam logic CFG_UPPER_TAIL = 1'b0;
  localparam logic CFG_LOG_PROB   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHAPE = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // k * ln2 in Q30 units
  function automatic logic [34:0] ln2_mul(input logic [4:0] k);
    logic [34:0] prod;
    prod = 35'(k) * 35'd744261118;
    return prod;
  endfunction

  // floor(2^32 / n) for the Taylor divisors
  function automatic logic [32:0] recip(input logic [3:0] n);
    logic [32:0] m;
    case (n)
      4'd1:    m = 33'd4294967296;
      4'd2:    m = 33'd2147483648;
      4'd3:    m = 33'd1431655765;
      4'd4:    m = 33'd1073741824;
      4'd5:    m = 33'd858993459;
      4'd6:    m = 33'd715827882;
      4'd7:    m = 33'd613566756;
      4'd8:    m = 33'd536870912;
      4'd9:    m = 33'd477218588;
      4'd10:   m = 33'd429496729;
      4'd11:   m = 33'd390451572;
      4'd12:   m = 33'd357913941;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/tqu_exp.sv @@
// Pipelined fixed-point exp() of a non-positive Q7.24 log probability.
module tqu_exp (
  input  logic                      clk,
  input  logic                      en,
  input  logic [31:0]               x,
  output logic [tqu_pkg::EXPW-1:0]  p
);
  import tqu_pkg::*;

  localparam logic signed [31:0] EXP_FLOOR = -32'sd285212672;  // -17.0
  localparam int NTERM = 12;

  typedef struct packed {
    logic        ovf;
    logic        flush;
    logic [4:0]  k;
    logic [29:0] r;
    logic [31:0] pos;
    logic [31:0] neg;
    logic [30:0] t;
    logic [30:0] v;
    logic [30:0] q;
  } exs_t;

  logic [32:0] negx;
  logic [34:0] y0_r;
  logic        ovf0_r;
  logic        flush0_r;
  logic [23:0] ge;
  logic [4:0]  k1;
  logic [34:0] r1;
  exs_t        st1_nxt;
  exs_t        st1_r;
  exs_t        a_r [NTERM];
  exs_t        b_r [NTERM];
  exs_t        c_r [NTERM];
  logic [31:0] e;
  logic [4:0]  sh;
  logic [32:0] rnd;
  logic [EXPW-1:0] p_r;

  // stage 0: y = -x in Q30
  assign negx = 33'd0 - {x[31], x};

  always_ff @(posedge clk) begin
    if (en) begin
      y0_r     <= {negx[28:0], 6'b0};
      ovf0_r   <= $signed(x) > 32'sd0;
      flush0_r <= $signed(x) < EXP_FLOOR;
    end
  end

  // stage 1: y = k*ln2 + r
  always_comb begin
    for (int j = 0; j < 24; j++) begin
      ge[j] = y0_r >= ln2_mul(5'(j + 1));
    end
    k1 = 5'($countones(ge));
    r1 = y0_r - ln2_mul(k1);
    st1_nxt       = '0;
    st1_nxt.ovf   = ovf0_r;
    st1_nxt.flush = flush0_r;
    st1_nxt.k     = k1;
    st1_nxt.r     = r1[29:0];
    st1_nxt.pos   = 32'h4000_0000;
    st1_nxt.t     = 31'h4000_0000;
  end

  always_ff @(posedge clk) begin
    if (en) st1_r <= st1_nxt;
  end

  // Taylor terms: multiply, reciprocal multiply, quotient fix-up
  for (genvar i = 0; i < NTERM; i++) begin : g_term
    localparam int N = i + 1;
    localparam bit ODD = (N % 2) == 1;
    exs_t        s_in;
    exs_t        a_nxt;
    exs_t        b_nxt;
    exs_t        c_nxt;
    logic [60:0] prod;
    logic [63:0] qm;
    logic [34:0] qn;
    logic [30:0] rem;
    logic [30:0] qc;

    if (i == 0) begin : g_first
      assign s_in = st1_r;
    end else begin : g_next
      assign s_in = c_r[i-1];
    end

    always_comb begin
      prod    = 61'(s_in.t) * 61'(s_in.r);
      a_nxt   = s_in;
      a_nxt.v = prod[60:30];
    end

    always_comb begin
      qm      = 64'(a_r[i].v) * 64'(recip(4'(N)));
      b_nxt   = a_r[i];
      b_nxt.q = qm[62:32];
    end

    always_comb begin
      qn    = 35'(b_r[i].q) * 35'(N);
      rem   = b_r[i].v - qn[30:0];
      qc    = (rem >= 31'(N)) ? b_r[i].q + 31'd1 : b_r[i].q;
      c_nxt = b_r[i];
      c_nxt.t = qc;
      if (ODD) c_nxt.neg = b_r[i].neg + 32'(qc);
      else     c_nxt.pos = b_r[i].pos + 32'(qc);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i] <= a_nxt;
        b_r[i] <= b_nxt;
        c_r[i] <= c_nxt;
      end
    end
  end

  // scale by 2^-(6+k), round half up
  assign e   = c_r[NTERM-1].pos - c_r[NTERM-1].neg;
  assign sh  = 5'd6 + c_r[NTERM-1].k;
  assign rnd = ({1'b0, e} + (33'd1 << (sh - 5'd1))) >> sh;

  always_ff @(posedge clk) begin
    if (en) begin
      if (c_r[NTERM-1].ovf)        p_r <= ONE_Q24 + EXPW'(1);
      else if (c_r[NTERM-1].flush) p_r <= '0;
      else                         p_r <= rnd[EXPW-1:0];
    end
  end

  assign p = p_r;

endmodule

@@ rtl/tqu_isqrt.sv @@
// Pipelined 64-bit integer square root, one root bit per stage.
module tqu_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);
  import tqu_pkg::*;

  logic [63:0] rem_r  [SQRT_LAT];
  logic [31:0] root_r [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_bit
    localparam int B = SQRT_LAT - 1 - i;
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [65:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (66'(root_in) << (B + 1)) + (66'd1 << (2 * B));
    assign take  = {2'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? rem_in - trial[63:0] : rem_in;
        root_r[i] <= take ? root_in | (32'd1 << B) : root_in;
      end
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

@@ rtl/triangular_quantile_unit.sv @@
// Triangular distribution quantile (inverse CDF): top level.
//
// Input stream in_*: one transfer carries prob (Q7.24), lower_bound, upper_bound
// and peak (Q15.16). Output stream out_*: one transfer per input with the
// quantile (Q15.16) and a status code (0 ok, 1 bad shape, 2 p outside [0,1]);
// the quantile is 0 whenever status is not ok.
// cfg_*: write upper_tail (index 0) and log_prob (index 1) while the block is
// idle; both clear at reset.
//
// Throughput: one transfer per cycle while the skid register is empty. The path
// is 39 stages of exp (12 Taylor terms, three stages each), 5 stages of shape
// check and 32-bit multiplies, 32 stages of bit-per-stage square root, then the
// output register.
// Stall: one skid register sits behind the output register; the pipeline keeps
// moving while the output register waits and freezes only when the skid
// register is also full, so no transfer is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and both output slots.
module triangular_quantile_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // prob, lower_bound, upper_bound, peak
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // quantile, status, zero pad
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic         cfg_wdata
);
  import tqu_pkg::*;

  localparam int   LAT = EXP_LAT + 5 + SQRT_LAT;  // stages carrying a valid bit

  // side data riding next to the exp unit
  typedef struct packed {
    logic [31:0] prob;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] pk;
    logic        tail;
    logic        logp;
  } eside_t;

  // after the shape/range check
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] len;
    logic [31:0] a;
    logic [31:0] b;
    logic [24:0] pu;
    status_t     status;
  } tst_t;

  // what the final add needs
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        lower;
    status_t     status;
  } mst_t;

  logic           upper_tail_r;
  logic           log_prob_r;
  logic           en;
  logic [LAT-1:0] vld_r;
  eside_t         e_side_r [EXP_LAT];
  eside_t         e_in;
  logic [EXPW-1:0] exp_p;

  // T stage
  eside_t             et;
  logic signed [33:0] p_src;
  logic signed [33:0] p_t;
  logic               shape_bad;
  logic               range_bad;
  tst_t               t_nxt;
  tst_t               t_r;

  // multiply stages
  logic [56:0] m1_r;
  tst_t        m1s_r;
  logic        lower2;
  logic [55:0] m2_m_r;
  logic [31:0] m2_d_r;
  mst_t        m2s_r;
  logic [55:0] ph_r;
  logic [63:0] pl_r;
  mst_t        m3s_r;
  logic [63:0] arg_r;
  mst_t        m4s_r;

  mst_t        s_side_r [SQRT_LAT];
  logic [31:0] root;
  mst_t        fs;
  logic [31:0] q_res;

  // output register and skid
  logic        out_vld_r;
  logic [31:0] out_q_r;
  status_t     out_st_r;
  logic        skid_vld_r;
  logic [31:0] skid_q_r;
  status_t     skid_st_r;
  logic        take;
  logic        fresh;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_tail_r <= 1'b0;
      log_prob_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPPER_TAIL: upper_tail_r <= cfg_wdata;
        CFG_LOG_PROB:   log_prob_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline moves unless the skid slot holds a result
  assign en        = !skid_vld_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // exp path, side data alongside
  assign e_in = '{prob: in_tdata[31:0], lo: in_tdata[63:32], hi: in_tdata[95:64],
                  pk: in_tdata[127:96], tail: upper_tail_r, logp: log_prob_r};

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r[0] <= e_in;
      for (int i = 1; i < EXP_LAT; i++) e_side_r[i] <= e_side_r[i-1];
    end
  end

  tqu_exp u_exp (
    .clk (clk),
    .en  (en),
    .x   (in_tdata[31:0]),
    .p   (exp_p)
  );

  // T: pick p, apply upper tail, classify
  assign et = e_side_r[EXP_LAT-1];

  always_comb begin
    p_src = et.logp ? $signed({9'b0, exp_p}) : $signed({{2{et.prob[31]}}, et.prob});
    p_t   = et.tail ? 34'sd16777216 - p_src : p_src;
    shape_bad = ($signed(et.lo) >= $signed(et.hi)) || ($signed(et.pk) > $signed(et.hi)) ||
                ($signed(et.lo) > $signed(et.pk));
    range_bad = (p_t < 34'sd0) || (p_t > 34'sd16777216);
    t_nxt.lo  = et.lo;
    t_nxt.hi  = et.hi;
    t_nxt.len = et.hi - et.lo;
    t_nxt.a   = et.pk - et.lo;
    t_nxt.b   = et.hi - et.pk;
    t_nxt.pu  = p_t[24:0];
    if (shape_bad)      t_nxt.status = ST_SHAPE;
    else if (range_bad) t_nxt.status = ST_RANGE;
    else                t_nxt.status = ST_OK;
  end

  // lower branch when p*len < (peak-lower)*2^24; upper product is len*2^24 - p*len
  assign lower2 = m1_r < {1'b0, m1s_r.a, 24'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
      // M1
      m1_r  <= 57'(t_r.pu) * 57'(t_r.len);
      m1s_r <= t_r;
      // M2
      m2_m_r <= lower2 ? m1_r[55:0] : {m1s_r.len, 24'b0} - m1_r[55:0];
      m2_d_r <= lower2 ? m1s_r.a : m1s_r.b;
      m2s_r  <= '{lo: m1s_r.lo, hi: m1s_r.hi, lower: lower2, status: m1s_r.status};
      // M3: split product times distance
      ph_r  <= 56'(m2_m_r[55:32]) * 56'(m2_d_r);
      pl_r  <= 64'(m2_m_r[31:0]) * 64'(m2_d_r);
      m3s_r <= m2s_r;
      // M4: root argument, floor(m*d / 2^24)
      arg_r <= {ph_r, 8'b0} + {24'b0, pl_r[63:24]};
      m4s_r <= m3s_r;
      // side data across the root
      s_side_r[0] <= m4s_r;
      for (int i = 1; i < SQRT_LAT; i++) s_side_r[i] <= s_side_r[i-1];
    end
  end

  tqu_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x    (arg_r),
    .root (root)
  );

  // final offset from the bound of the chosen branch
  assign fs = s_side_r[SQRT_LAT-1];

  always_comb begin
    if (fs.status != ST_OK) q_res = '0;
    else if (fs.lower)      q_res = fs.lo + root;
    else                    q_res = fs.hi - root;
  end

  assign take  = out_vld_r && out_tready;
  assign fresh = en && vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        out_q_r    <= skid_q_r;
        out_st_r   <= skid_st_r;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || take) begin
      out_vld_r <= fresh;
      if (fresh) begin
        out_q_r  <= q_res;
        out_st_r <= fs.status;
      end
    end else if (fresh) begin
      skid_q_r   <= q_res;
      skid_st_r  <= fs.status;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_st_r, out_q_r};

  // skid slot only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full with output register empty");

  // a bad status always carries a zero quantile
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_st_r != ST_OK) |-> (out_q_r == 32'd0))
    else $error("nonzero quantile with bad status");

  // a held result is still there next cycle
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> out_vld_r)
    else $error("output result dropped while stalled");

  // while the skid slot is full and the output stalls, the skid result stays and the pipeline freezes
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_tready) |=> (skid_vld_r && $stable(vld_r)))
    else $error("pipeline moved while skid register held a result");

endmodule
